### design/lpht_pkg.sv
// Shared constants, codes and hash functions for the linear probe hash table.
`timescale 1ns / 1ps
package lpht_pkg;

    localparam int DefTableSlots  = 256;
    localparam int DefKeyLenBytes = 8;
    localparam int DefValueBits   = 32;

    localparam logic [1:0] OP_PUT    = 2'd0;
    localparam logic [1:0] OP_GET    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISSING  = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BADPARAM = 2'd3;

    function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] t;
        t = h + {24'd0, b};
        t = t + (t << 10);
        t = t ^ (t >> 6);
        return t;
    endfunction

    function automatic logic [31:0] hash_final(input logic [31:0] h);
        logic [31:0] t;
        t = h + (h << 3);
        t = t ^ (t >> 11);
        t = t + (t << 15);
        return t;
    endfunction

endpackage

### design/lpht_ram.sv
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

### design/lpht_fifo.sv
// Two-entry queue between the request front end and the table engine.
`timescale 1ns / 1ps
module lpht_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end
endmodule

### design/lpht_front.sv
// Request front end: key trimming and one-at-a-time hashing, one byte per cycle.
`timescale 1ns / 1ps
module lpht_front #(
    parameter int TABLE_SLOTS   = lpht_pkg::DefTableSlots,
    parameter int KEY_LEN_BYTES = lpht_pkg::DefKeyLenBytes,
    parameter int VALUE_BITS    = lpht_pkg::DefValueBits,
    localparam int SLOT_W = $clog2(TABLE_SLOTS),
    localparam int KEY_W  = KEY_LEN_BYTES * 8,
    localparam int ITEM_W = 2 + KEY_W + VALUE_BITS + SLOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [63:0]       key_bytes,
    input  logic [31:0]       value_word,
    output logic              push_valid,
    input  logic              push_ready,
    output logic [ITEM_W-1:0] push_data
);
    import lpht_pkg::*;

    localparam int IDX_W = (KEY_LEN_BYTES > 1) ? $clog2(KEY_LEN_BYTES) : 1;

    typedef enum logic [1:0] {F_IDLE, F_HASH, F_PUSH} front_state_t;

    front_state_t          state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [31:0]           hash_reg, hash_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic [KEY_W-1:0]      key_trim;
    logic [63:0]           value_wide;
    logic [7:0]            cur_byte;
    logic [31:0]           hash_done;

    always_comb
    begin
        logic alive;
        alive = 1'b1;
        for (int i = 0; i < KEY_LEN_BYTES; i++)
        begin
            if (key_bytes[8*i +: 8] == 8'd0)
            begin
                alive = 1'b0;
            end
            key_trim[8*i +: 8] = alive ? key_bytes[8*i +: 8] : 8'd0;
        end
    end

    assign value_wide = {32'd0, value_word};
    assign cur_byte   = key_reg[cnt_reg*8 +: 8];
    assign hash_done  = hash_final(hash_reg);
    assign in_ready   = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {op_reg, key_reg, val_reg, hash_done[SLOT_W-1:0]};

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        hash_next  = hash_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = opcode;
                    key_next   = key_trim;
                    val_next   = value_wide[VALUE_BITS-1:0];
                    hash_next  = 32'd0;
                    cnt_next   = '0;
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                if (cur_byte == 8'd0)
                begin
                    state_next = F_PUSH;
                end
                else
                begin
                    hash_next = hash_step(hash_reg, cur_byte);
                    if (cnt_reg == IDX_W'(KEY_LEN_BYTES - 1))
                    begin
                        state_next = F_PUSH;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        val_reg  <= val_next;
        hash_reg <= hash_next;
        cnt_reg  <= cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

### design/lpht_back.sv
// Table engine: probing, insert, lookup, backward-shift removal and result register.
`timescale 1ns / 1ps
module lpht_back #(
    parameter int TABLE_SLOTS   = lpht_pkg::DefTableSlots,
    parameter int KEY_LEN_BYTES = lpht_pkg::DefKeyLenBytes,
    parameter int VALUE_BITS    = lpht_pkg::DefValueBits,
    localparam int SLOT_W = $clog2(TABLE_SLOTS),
    localparam int KEY_W  = KEY_LEN_BYTES * 8,
    localparam int ITEM_W = 2 + KEY_W + VALUE_BITS + SLOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  logic [ITEM_W-1:0] pop_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic [31:0]       read_value,
    output logic [8:0]        entry_total
);
    import lpht_pkg::*;

    localparam int WORD_W = SLOT_W + KEY_W + VALUE_BITS;
    localparam int STEP_W = SLOT_W - 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TABLE_SLOTS / 2 - 1);

    typedef enum logic [2:0] {B_IDLE, B_PROBE, B_CMP, B_SCHK, B_SCMP, B_RESP} back_state_t;

    back_state_t           state_reg, state_next;
    logic [1:0]            op_reg, op_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [SLOT_W-1:0]     home_reg, home_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [SLOT_W-1:0]     hole_reg, hole_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [VALUE_BITS-1:0] res_value_reg, res_value_next;
    logic                  out_valid_reg, out_valid_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [VALUE_BITS-1:0] out_value_reg, out_value_next;
    logic [8:0]            out_total_reg, out_total_next;

    logic                  ram_we;
    logic [SLOT_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;
    logic [SLOT_W-1:0]     rd_home;
    logic [KEY_W-1:0]      rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic [SLOT_W-1:0]     in_home;
    logic [KEY_W-1:0]      in_key;
    logic [VALUE_BITS-1:0] in_value;
    logic [1:0]            in_op;
    logic [SLOT_W-1:0]     home_gap;
    logic [63:0]           value_wide;

    lpht_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_SLOTS)
    ) u_slot_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(idx_reg),
        .rdata(ram_rdata)
    );

    assign {in_op, in_key, in_value, in_home} = pop_data;
    assign {rd_home, rd_key, rd_value}         = ram_rdata;
    assign home_gap   = rd_home - hole_reg;
    assign pop_ready  = (state_reg == B_IDLE);
    assign value_wide = 64'(out_value_reg);
    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = value_wide[31:0];
    assign entry_total = out_total_reg;

    always_comb
    begin
        logic [SLOT_W-1:0] new_hole;
        new_hole        = hole_reg;
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        home_next       = home_reg;
        idx_next        = idx_reg;
        hole_next       = hole_reg;
        step_next       = step_reg;
        count_next      = count_reg;
        valid_next      = valid_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_total_next  = out_total_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {home_reg, key_reg, val_reg};
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    op_next         = in_op;
                    key_next        = in_key;
                    val_next        = in_value;
                    home_next       = in_home;
                    idx_next        = in_home;
                    step_next       = '0;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    state_next      = B_PROBE;
                    if (in_op == OP_PUT)
                    begin
                        if (in_value == '0)
                        begin
                            res_status_next = ST_BADPARAM;
                            state_next      = B_RESP;
                        end
                    end
                    else if (in_op == OP_GET || in_op == OP_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_MISSING;
                            state_next      = B_RESP;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_BADPARAM;
                        state_next      = B_RESP;
                    end
                end
            end
            B_PROBE:
            begin
                if (!valid_reg[idx_reg])
                begin
                    if (op_reg == OP_PUT)
                    begin
                        ram_we              = 1'b1;
                        valid_next[idx_reg] = 1'b1;
                        count_next          = count_reg + 1'b1;
                    end
                    else
                    begin
                        res_status_next = ST_MISSING;
                    end
                    state_next = B_RESP;
                end
                else
                begin
                    state_next = B_CMP;
                end
            end
            B_CMP:
            begin
                if (rd_key == key_reg)
                begin
                    case (op_reg)
                        OP_PUT:
                        begin
                            ram_we     = 1'b1;
                            ram_wdata  = {rd_home, key_reg, val_reg};
                            state_next = B_RESP;
                        end
                        OP_GET:
                        begin
                            res_value_next = rd_value;
                            state_next     = B_RESP;
                        end
                        default:
                        begin
                            count_next = count_reg - 1'b1;
                            hole_next  = idx_reg;
                            idx_next   = idx_reg + 1'b1;
                            step_next  = '0;
                            state_next = B_SCHK;
                        end
                    endcase
                end
                else if (step_reg == LAST_STEP)
                begin
                    res_status_next = (op_reg == OP_PUT) ? ST_FULL : ST_MISSING;
                    state_next      = B_RESP;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_PROBE;
                end
            end
            B_SCHK:
            begin
                if (!valid_reg[idx_reg])
                begin
                    valid_next[hole_reg] = 1'b0;
                    state_next           = B_RESP;
                end
                else
                begin
                    state_next = B_SCMP;
                end
            end
            B_SCMP:
            begin
                if (rd_home == hole_reg || home_gap[SLOT_W-1])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = hole_reg;
                    ram_wdata = ram_rdata;
                    new_hole  = idx_reg;
                end
                hole_next = new_hole;
                if (step_reg == LAST_STEP)
                begin
                    valid_next[new_hole] = 1'b0;
                    state_next           = B_RESP;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_SCHK;
                end
            end
            B_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_value_next  = res_value_reg;
                    out_total_next  = 9'(count_reg);
                    state_next      = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        home_reg       <= home_next;
        idx_reg        <= idx_next;
        hole_reg       <= hole_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_total_reg  <= out_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

### design/linear_probe_hash_table.sv
// Top level of the linear probe hash table.
// Each request word puts, gets or removes a key of up to KEY_LEN_BYTES bytes and
// returns one result word with a status, the value found by a get and the entry
// count. The front end accepts a request, then hashes one key byte per cycle,
// stopping at the terminating zero byte when the key is shorter than
// KEY_LEN_BYTES. It then hands the request to a two-entry queue, waiting while
// the queue is full, and the next request is taken on the following cycle. The
// front end takes no new request until it has handed the last one to the queue.
// The table engine takes a request from the queue and, for each occupied slot it
// probes, does a valid check, then a key compare on the registered slot memory
// read. An empty slot or a matching key ends the probe. During backward-shift
// removal each slot moved or skipped gets a valid check and a home compare, and a
// valid check on an empty slot ends the shift. The engine then loads the result
// register, waiting while the last result has not been taken, and takes no new
// request until it has done so.
// Slot valid bits are cleared at reset; no clearing pass is needed.
`timescale 1ns / 1ps
module linear_probe_hash_table #(
    parameter int TABLE_SLOTS   = lpht_pkg::DefTableSlots,
    parameter int KEY_LEN_BYTES = lpht_pkg::DefKeyLenBytes,
    parameter int VALUE_BITS    = lpht_pkg::DefValueBits
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] key_bytes,
    input  logic [31:0] value_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] read_value,
    output logic [8:0]  entry_total
);
    localparam int ITEM_W = 2 + KEY_LEN_BYTES * 8 + VALUE_BITS + $clog2(TABLE_SLOTS);

    logic              push_valid;
    logic              push_ready;
    logic [ITEM_W-1:0] push_data;
    logic              pop_valid;
    logic              pop_ready;
    logic [ITEM_W-1:0] pop_data;

    lpht_front #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .KEY_LEN_BYTES(KEY_LEN_BYTES),
        .VALUE_BITS   (VALUE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .key_bytes (key_bytes),
        .value_word(value_word),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data)
    );

    lpht_fifo #(
        .WIDTH(ITEM_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    lpht_back #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .KEY_LEN_BYTES(KEY_LEN_BYTES),
        .VALUE_BITS   (VALUE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .read_value (read_value),
        .entry_total(entry_total)
    );
endmodule

### verif/tb_top.sv
// Self-checking testbench for the linear probe hash table with random traffic and handshakes.
`timescale 1ns / 1ps
module tb_top;
    import lpht_pkg::*;

    localparam int SLOTS = 256;
    localparam int POOL = 320;
    localparam int IDLE_LIMIT = 5000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    class kv_scoreboard;
        typedef struct {
            logic [1:0]  st;
            logic [31:0] rd;
            logic [8:0]  tot;
        } result_t;

        bit          occupied[SLOTS];
        logic [63:0] slot_key[SLOTS];
        logic [31:0] slot_val[SLOTS];
        int          entries;
        result_t     awaited[$];
        int          errors;
        int          checked;
        int          status_seen[4];

        function logic [63:0] trim_key(logic [63:0] raw);
            logic [63:0] k;
            k = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (raw[8*i +: 8] == 8'd0)
                    break;
                k[8*i +: 8] = raw[8*i +: 8];
            end
            return k;
        endfunction

        function int slot_of(logic [63:0] k);
            logic [31:0] h;
            h = '0;
            for (int i = 0; i < 8; i++)
            begin
                if (k[8*i +: 8] == 8'd0)
                    break;
                h = h + {24'd0, k[8*i +: 8]};
                h = h + (h << 10);
                h = h ^ (h >> 6);
            end
            h = h + (h << 3);
            h = h ^ (h >> 11);
            h = h + (h << 15);
            return int'(h & (SLOTS - 1));
        endfunction

        function int find_slot(logic [63:0] k, bit want_empty);
            int idx;
            idx = slot_of(k);
            for (int i = 0; i < SLOTS / 2; i++)
            begin
                if (!occupied[idx])
                    return want_empty ? idx : -1;
                if (slot_key[idx] == k)
                    return idx;
                idx = (idx + 1) & (SLOTS - 1);
            end
            return -1;
        endfunction

        function void shift_out(int hole);
            int idx;
            int h;
            idx = (hole + 1) & (SLOTS - 1);
            entries--;
            for (int i = 0; i < SLOTS / 2; i++)
            begin
                if (!occupied[idx])
                    break;
                h = slot_of(slot_key[idx]);
                if (h == hole || ((((h - hole) & (SLOTS - 1)) & (SLOTS / 2)) != 0))
                begin
                    slot_key[hole] = slot_key[idx];
                    slot_val[hole] = slot_val[idx];
                    hole = idx;
                end
                idx = (idx + 1) & (SLOTS - 1);
            end
            occupied[hole] = 1'b0;
        endfunction

        function void note_request(logic [1:0] op, logic [63:0] raw, logic [31:0] val);
            result_t r;
            logic [63:0] k;
            int pos;
            k = trim_key(raw);
            r.st = ST_OK;
            r.rd = '0;
            if (op == OP_PUT)
            begin
                if (val == 32'd0)
                    r.st = ST_BADPARAM;
                else
                begin
                    pos = find_slot(k, 1'b1);
                    if (pos < 0)
                        r.st = ST_FULL;
                    else
                    begin
                        if (!occupied[pos])
                        begin
                            occupied[pos] = 1'b1;
                            slot_key[pos] = k;
                            entries++;
                        end
                        slot_val[pos] = val;
                    end
                end
            end
            else if (op == OP_GET || op == OP_REMOVE)
            begin
                pos = (entries == 0) ? -1 : find_slot(k, 1'b0);
                if (pos < 0)
                    r.st = ST_MISSING;
                else if (op == OP_GET)
                    r.rd = slot_val[pos];
                else
                    shift_out(pos);
            end
            else
                r.st = ST_BADPARAM;
            r.tot = entries[8:0];
            awaited.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [31:0] rd, logic [8:0] tot);
            result_t r;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result word status=%0d read_value=%h entry_total=%0d",
                         $time, st, rd, tot);
                errors++;
                return;
            end
            r = awaited.pop_front();
            checked++;
            status_seen[st]++;
            if (st !== r.st)
            begin
                $display("%0t: status expected %0d actual %0d", $time, r.st, st);
                errors++;
            end
            if (rd !== r.rd)
            begin
                $display("%0t: read_value expected %h actual %h", $time, r.rd, rd);
                errors++;
            end
            if (tot !== r.tot)
            begin
                $display("%0t: entry_total expected %0d actual %0d", $time, r.tot, tot);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [63:0] key_bytes;
    logic [31:0] value_word;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  entry_total;

    kv_scoreboard sb;
    logic [63:0] key_pool[POOL];
    logic        hold_req;
    logic        hold_seen;
    int          hold_cnt;
    int          rx_mode;
    int          rx_tick;
    int          idle_cycles;
    int          sent;

    linear_probe_hash_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key_bytes   (key_bytes),
        .value_word  (value_word),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .read_value  (read_value),
        .entry_total (entry_total)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if (in_valid && in_ready && rst_n)
            sb.note_request(opcode, key_bytes, value_word);
        if (out_valid && out_ready && rst_n)
            sb.check_result(status, read_value, entry_total);
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout after %0d cycles without progress.", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 64 == 63)
            rx_mode <= $urandom_range(0, 3);
        if (hold_req && !hold_seen)
        begin
            hold_seen <= 1'b1;
            hold_cnt <= 300;
            out_ready <= 1'b0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    function automatic logic [63:0] random_key(int len);
        logic [63:0] k;
        k = {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
        begin
            if (i < len)
                k[8*i +: 8] = 8'($urandom_range(1, 255));
            else if (i == len)
                k[8*i +: 8] = 8'd0;
        end
        return k;
    endfunction

    function automatic logic [63:0] pool_key(int n);
        logic [63:0] k;
        int len;
        k = key_pool[n];
        len = 8;
        for (int i = 0; i < 8; i++)
        begin
            if (k[8*i +: 8] == 8'd0)
            begin
                len = i;
                break;
            end
        end
        for (int i = len + 1; i < 8; i++)
            k[8*i +: 8] = 8'($urandom);
        return k;
    endfunction

    task automatic send_word(logic [1:0] op, logic [63:0] k, logic [31:0] v);
        in_valid <= 1'b1;
        opcode <= op;
        key_bytes <= k;
        value_word <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic pause_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic random_phase(int count, int put_w, int get_w, int rm_w);
        int burst;
        int pick;
        logic [1:0] op;
        logic [31:0] v;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, put_w + get_w + rm_w + 4);
            if (pick < put_w)
                op = OP_PUT;
            else if (pick < put_w + get_w)
                op = OP_GET;
            else if (pick < put_w + get_w + rm_w)
                op = OP_REMOVE;
            else
                op = 2'($urandom_range(0, 3));
            v = $urandom;
            if ($urandom_range(0, 29) == 0)
                v = 32'd0;
            else if (v == 32'd0)
                v = 32'd1;
            if ($urandom_range(0, 19) == 0)
                send_word(op, random_key($urandom_range(0, 8)), v);
            else
                send_word(op, pool_key($urandom_range(0, POOL - 1)), v);
            burst--;
            if (burst == 0)
            begin
                pause_sender($urandom_range(1, 12));
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_PUT;
        key_bytes = '0;
        value_word = '0;
        out_ready = 1'b0;
        hold_req = 1'b0;
        hold_seen = 1'b0;
        hold_cnt = 0;
        rx_mode = 0;
        rx_tick = 0;
        idle_cycles = 0;
        sent = 0;
        for (int i = 0; i < POOL; i++)
            key_pool[i] = random_key((i % 3 == 0) ? 8 : $urandom_range(0, 8));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_GET, 64'h0000_0000_0000_6162, 32'd0);
        send_word(OP_REMOVE, 64'h0000_0000_0000_0000, 32'd0);
        send_word(OP_PUT, 64'h1234_0000_0000_0041, 32'd0);
        send_word(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd5);
        send_word(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_PUT, 64'hABCD_EF00_0000_0000, 32'd1);
        send_word(OP_PUT, 64'h0000_0000_0000_0001, 32'h8000_0000);
        send_word(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_word(OP_GET, 64'h5555_0000_0000_0000, 32'd0);
        send_word(OP_GET, 64'h0000_0000_0000_0001, 32'd0);
        send_word(OP_PUT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0007);
        send_word(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_word(OP_GET, 64'h0000_0000_0000_7A7A, 32'd0);
        send_word(OP_REMOVE, 64'h0000_0000_0000_7A7A, 32'd0);
        send_word(OP_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_word(OP_GET, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        send_word(OP_UNUSED, 64'h0000_0000_0000_0000, 32'd0);
        send_word(OP_REMOVE, 64'h0000_0000_0000_0001, 32'd0);
        send_word(OP_REMOVE, 64'h0000_0000_0000_0000, 32'd0);
        send_word(OP_GET, 64'h0000_0000_0000_0000, 32'd0);

        random_phase(500, 14, 3, 2);
        hold_req <= 1'b1;
        random_phase(400, 6, 5, 5);
        pause_sender(1);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        random_phase(400, 2, 4, 12);

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        $display("Sent %0d requests and checked %0d results.", sent, sb.checked);
        $display("Status counts: ok %0d, missing %0d, full %0d, bad parameter %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_MISSING],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_BADPARAM]);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

### filelist.f
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_fifo.sv
design/lpht_front.sv
design/lpht_back.sv
design/linear_probe_hash_table.sv
verif/tb_top.sv
